[hdl/fec_pkg.sv]
// Shared constants, types and a helper function for the feedback echo comb.
package fec_pkg;

  // Sample format
  localparam int SAMPLE_W = 16;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Delay store geometry
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  // Configuration registers
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_SAMPLES = 2'd0,
    REG_DECAY         = 2'd1
  } cfg_reg_t;

  // Handshake events from the top level to the address unit
  typedef struct packed {
    logic accept;  // new beat enters the compute stage, store read issued
    logic fire;    // compute stage result leaves and is written back
  } addr_ctl_t;

  // Per-beat read qualifiers, registered alongside the store read
  typedef struct packed {
    logic fwd;     // echo comes from the result written in the read cycle
    logic zero;    // entry not written since reset, reads as zero
  } rd_tag_t;

  // Delay of zero acts as one; clamp to the longest delay the store holds
  function automatic logic [ADDR_W-1:0] eff_delay(input logic [CFG_W-1:0] ds);
    logic [ADDR_W-1:0] d;
    if (ds == '0) begin
      d = ADDR_W'(1);
    end else if (32'(ds) > 32'(STORE_DEPTH - 1)) begin
      d = ADDR_W'(STORE_DEPTH - 1);
    end else begin
      d = ADDR_W'(ds);
    end
    return d;
  endfunction

endpackage

[hdl/fec_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module fec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read of the address being written returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/fec_addr.sv]
// Address unit: write pointer, echo read address, fill count and forwarding check.
module fec_addr import fec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CFG_W-1:0]  delay_samples,
  input  addr_ctl_t         ctl,
  output logic [ADDR_W-1:0] raddr,
  output logic [ADDR_W-1:0] waddr,
  output rd_tag_t           tag
);

  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] wp_next;
  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] dly;
  logic [ADDR_W:0]   diff;

  assign dly = eff_delay(delay_samples);

  // Echo address = write pointer minus delay, modulo store depth
  always_comb begin
    diff = {1'b0, wp} - {1'b0, dly};
    if (diff[ADDR_W]) begin
      raddr = ADDR_W'(diff + (ADDR_W + 1)'(STORE_DEPTH));
    end else begin
      raddr = diff[ADDR_W-1:0];
    end
  end

  assign wp_next = (wp == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wp + 1'b1;

  // Pointer and fill count advance per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
      tag  <= '0;
    end else if (ctl.accept) begin
      wp <= wp_next;
      if (fill != CNT_W'(STORE_DEPTH)) begin
        fill <= fill + 1'b1;
      end
      // the beat in the compute stage writes its result this same cycle
      tag.fwd  <= ctl.fire && (waddr == raddr);
      // fewer beats since reset than the delay: entry was never written
      tag.zero <= fill < CNT_W'(dly);
    end
  end

  // Write address of the beat held in the compute stage
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      waddr <= wp;
    end
  end

endmodule

[hdl/feedback_echo_comb.sv]
// An input beat passes the compute stage register and then the output register.
// Throughput: one beat per cycle at any delay unless out_ready stalls the output;
//   at a delay of one the recurrence is closed by forwarding the written result into the next beat.
// The loop is one store read, one 16x17 multiply, an add and a clamp per beat.
// Reset: delay_samples = 1, decay = 0, pipeline empty. The store is not swept;
//   a fill count makes entries not written since reset read as zero.
module feedback_echo_comb import fec_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  logic [CFG_W-1:0]           delay_samples;
  logic [CFG_W-1:0]           decay;
  logic                       stg_valid;
  logic signed [SAMPLE_W-1:0] stg_sample;
  logic signed [SAMPLE_W-1:0] fwd_data;
  logic                       stg_fire;
  logic                       accept;
  addr_ctl_t                  ctl;
  rd_tag_t                    tag;
  logic [ADDR_W-1:0]          raddr;
  logic [ADDR_W-1:0]          waddr;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] echo;
  logic signed [32:0]         prod;
  logic signed [32:0]         prod_adj;
  logic signed [17:0]         fb;
  logic signed [18:0]         sum;
  logic signed [SAMPLE_W-1:0] result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= CFG_W'(1);
      decay         <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY_SAMPLES: delay_samples <= cfg_data;
        REG_DECAY:         decay         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: compute stage advances when the output register can take it
  assign stg_fire = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || stg_fire;
  assign accept   = in_valid && in_ready;

  assign ctl.accept = accept;
  assign ctl.fire   = stg_fire;

  fec_addr u_addr (
    .clk           (clk),
    .rst           (rst),
    .delay_samples (delay_samples),
    .ctl           (ctl),
    .raddr         (raddr),
    .waddr         (waddr),
    .tag           (tag)
  );

  fec_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (stg_fire),
    .waddr (waddr),
    .wdata (result),
    .re    (accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Echo select: forwarded result, unwritten entry, or store data
  always_comb begin
    if (tag.fwd) begin
      echo = fwd_data;
    end else if (tag.zero) begin
      echo = '0;
    end else begin
      echo = $signed(rdata);
    end
  end

  // Scale by Q1.15 gain, truncate toward zero, add and clamp
  always_comb begin
    prod     = echo * $signed({1'b0, decay});
    prod_adj = prod + (prod[32] ? 33'sd32767 : 33'sd0);
    fb       = prod_adj[32:15];
    sum      = {{3{stg_sample[SAMPLE_W-1]}}, stg_sample} + {fb[17], fb};
    if (sum > 19'(SAMPLE_MAX)) begin
      result = SAMPLE_MAX;
    end else if (sum < 19'(SAMPLE_MIN)) begin
      result = SAMPLE_MIN;
    end else begin
      result = sum[SAMPLE_W-1:0];
    end
  end

  // Compute stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (stg_fire) begin
      stg_valid <= 1'b0;
    end
  end

  // Compute stage payload and forwarded result
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_sample <= sample_in;
      fwd_data   <= result;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_fire) begin
      sample_out <= result;
    end
  end

endmodule

[hdl/fec_chk.sv]
// Port-level checker for the feedback echo comb, bound to the top level.
module fec_chk import fec_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [SAMPLE_W-1:0] sample_in,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] sample_out
);

  // Reset empties the pipeline and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // With no result waiting, the input side is never held off
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // A beat taken while the output is empty passes the compute stage and reaches the output
  a_beat_arrives: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
    else $error("accepted beat did not reach the output");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
    else $error("output beat changed while stalled");

  // A waiting input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> (in_valid && $stable(sample_in)))
    else $error("input beat changed while waiting");

endmodule

bind feedback_echo_comb fec_chk u_fec_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .sample_in  (sample_in),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);
